// ===== src/nct_pkg.sv =====
`timescale 1ns / 1ps
package nct_pkg;

	localparam int PAYLOAD_BYTES_DEF = 64;
	localparam int SYNC_BITS         = 32;
	localparam int APB_AW            = 4;
	localparam int APB_DW            = 32;

	localparam logic [7:0]  CRC_POLY         = 8'h07;
	localparam logic [14:0] AMPLITUDE_RST    = 15'd15000;
	localparam logic [7:0]  SPS_RST          = 8'd50;
	localparam logic [31:0] FRAME_MARKER_RST = 32'h1ACF_FC1D;

	typedef enum logic [1:0] {
		REG_AMPLITUDE    = 2'd0,
		REG_SPS          = 2'd1,
		REG_FRAME_MARKER = 2'd2
	} reg_idx_t;

	typedef logic        req_type_t;
	typedef logic [5:0]  byte_index_t;
	typedef logic [7:0]  byte_value_t;
	typedef logic signed [15:0] sample_value_t;

	localparam req_type_t REQ_LOAD = 1'b0;
	localparam req_type_t REQ_TICK = 1'b1;

	typedef struct packed {
		logic [14:0] amplitude;
		logic [7:0]  samples_per_symbol;
		logic [31:0] frame_marker;
	} cfg_t;

	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic b);
		logic fb;
		fb = crc[7] ^ b;
		crc_step = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
	endfunction

endpackage

// ===== src/nct_if.sv =====
`timescale 1ns / 1ps
interface nct_req_if;
	logic                 valid;
	logic                 ready;
	nct_pkg::req_type_t   req_type;
	nct_pkg::byte_index_t byte_index;
	nct_pkg::byte_value_t byte_value;

	modport source (output valid, req_type, byte_index, byte_value, input ready);
	modport sink (input valid, req_type, byte_index, byte_value, output ready);
endinterface

interface nct_smp_if;
	logic                   valid;
	logic                   ready;
	nct_pkg::sample_value_t sample_value;
	logic                   sent_bit;
	logic                   packet_start;
	logic                   packet_end;

	modport source (output valid, sample_value, sent_bit, packet_start, packet_end,
		input ready);
	modport sink (input valid, sample_value, sent_bit, packet_start, packet_end,
		output ready);
endinterface

// ===== src/nct_ram.sv =====
`timescale 1ns / 1ps
module nct_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 63,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/nct_cfg_regs.sv =====
`timescale 1ns / 1ps
module nct_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [nct_pkg::APB_AW-1:0] paddr,
	input  logic [nct_pkg::APB_DW-1:0] pwdata,
	output logic [nct_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output nct_pkg::cfg_t              cfg
);
	import nct_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amplitude          <= AMPLITUDE_RST;
			cfg_q.samples_per_symbol <= SPS_RST;
			cfg_q.frame_marker       <= FRAME_MARKER_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_AMPLITUDE:    cfg_q.amplitude          <= pwdata[14:0];
				REG_SPS:          cfg_q.samples_per_symbol <= pwdata[7:0];
				REG_FRAME_MARKER: cfg_q.frame_marker       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_AMPLITUDE:    prdata = {17'd0, cfg_q.amplitude};
			REG_SPS:          prdata = {24'd0, cfg_q.samples_per_symbol};
			REG_FRAME_MARKER: prdata = cfg_q.frame_marker;
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== src/nrz_crc8_frame_transmitter.sv =====
`timescale 1ns / 1ps
// Sync-word framer with serial CRC-8 and NRZ/BPSK in-phase sample output.
// The req channel carries two kinds of transfer: a load writes one payload
// byte into the store, a tick asks for one sample. Each tick yields exactly
// one transfer on the smp channel; a load yields none. Packets repeat without
// a gap: the frame marker, the stored payload bytes, then the CRC-8 byte, each
// bit held for samples_per_symbol ticks. An accepted item is registered in the
// input stage; a tick's sample is then registered in the output register and
// shown on smp. One item is taken every cycle unless smp stalls; the rate is set
// by the single input stage and the output register, and the store is read at
// the next bit position, ahead of the bit it feeds. The user writes
// configuration over the APB port only while the block is idle; the block does
// not enforce this. Reset clears the store's valid flags (bytes read as zero
// until written), puts the transmitter at the first sample of a packet and loads
// register defaults. When smp stalls, the output holds, a pending tick waits
// in the input stage and req.ready drops; loads flow while that stage is free.
module nrz_crc8_frame_transmitter #(
	parameter int PAYLOAD_BYTES = nct_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	nct_req_if.sink                    req,
	nct_smp_if.source                  smp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [nct_pkg::APB_AW-1:0] paddr,
	input  logic [nct_pkg::APB_DW-1:0] pwdata,
	output logic [nct_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import nct_pkg::*;

	localparam int STORE_BYTES = PAYLOAD_BYTES - 1;
	localparam int FRAME_BITS  = SYNC_BITS + 8 * PAYLOAD_BYTES;
	localparam int PW          = $clog2(FRAME_BITS);
	localparam int AW          = $clog2(PAYLOAD_BYTES);
	localparam logic [PW-1:0] POS_SYNC_END = PW'(SYNC_BITS);
	localparam logic [PW-1:0] POS_LAST     = PW'(FRAME_BITS - 1);
	localparam logic [AW-1:0] IDX_CRC      = AW'(STORE_BYTES);

	cfg_t cfg;

	nct_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input stage.
	logic        valid_s1;
	req_type_t   req_type_s1;
	byte_index_t byte_index_s1;
	byte_value_t byte_value_s1;

	// Transmitter state.
	logic [PW-1:0] bit_pos_q;
	logic [7:0]    sample_cnt_q;
	logic [7:0]    crc_q;

	// Output register.
	logic          out_valid_q;
	sample_value_t sample_value_q;
	logic          sent_bit_q;
	logic          packet_start_q;
	logic          packet_end_q;

	// Store access.
	logic [STORE_BYTES-1:0] byte_vld_q;
	logic                   rd_vld_q;
	logic                   fwd_hit_q;
	logic [7:0]             fwd_data_q;
	logic [7:0]             ram_rdata;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic                   wr_en;

	logic          out_free;
	logic          is_tick;
	logic          tick_go;
	logic          s1_go;
	logic          first;
	logic          last;
	logic          in_sync;
	logic          in_payload;
	logic          cur_bit;
	logic [PW-1:0] q_off;
	logic [AW-1:0] cur_idx;
	logic [7:0]    cur_byte;
	logic [7:0]    crc_eff;
	logic [7:0]    crc_d;
	logic [7:0]    sps_eff;
	logic [PW-1:0] bit_pos_d;
	logic [7:0]    sample_cnt_d;
	logic [PW-1:0] q_off_d;
	logic [AW-1:0] idx_d;
	logic [15:0]   amp_ext;

	assign out_free  = !out_valid_q || smp.ready;
	assign is_tick   = (req_type_s1 == REQ_TICK);
	assign tick_go   = valid_s1 && is_tick && out_free;
	assign s1_go     = valid_s1 && (!is_tick || out_free);
	assign req.ready = !valid_s1 || s1_go;

	assign wr_en   = valid_s1 && !is_tick && (9'(byte_index_s1) < 9'(STORE_BYTES));
	assign wr_addr = AW'(byte_index_s1);

	always_comb begin
		first   = (bit_pos_q == '0) && (sample_cnt_q == 8'd0);
		crc_eff = first ? 8'h00 : crc_q;
		in_sync = bit_pos_q < POS_SYNC_END;
		q_off   = bit_pos_q - POS_SYNC_END;
		cur_idx = AW'(q_off >> 3);
		in_payload = !in_sync && (cur_idx < IDX_CRC);
		if (fwd_hit_q) begin
			cur_byte = fwd_data_q;
		end else if (rd_vld_q) begin
			cur_byte = ram_rdata;
		end else begin
			cur_byte = 8'h00;
		end
		if (in_sync) begin
			cur_bit = cfg.frame_marker[~bit_pos_q[4:0]];
		end else if (in_payload) begin
			cur_bit = cur_byte[~q_off[2:0]];
		end else begin
			cur_bit = crc_eff[7];
		end
		sps_eff = (cfg.samples_per_symbol == 8'd0) ? 8'd1 : cfg.samples_per_symbol;
		last    = ({1'b0, sample_cnt_q} + 9'd1) >= {1'b0, sps_eff};

		bit_pos_d    = bit_pos_q;
		sample_cnt_d = sample_cnt_q;
		crc_d        = crc_q;
		if (tick_go) begin
			crc_d = crc_eff;
			if (last) begin
				if (in_payload) begin
					crc_d = crc_step(crc_eff, cur_bit);
				end else if (!in_sync) begin
					crc_d = {crc_eff[6:0], 1'b0};
				end
				sample_cnt_d = 8'd0;
				bit_pos_d    = (bit_pos_q == POS_LAST) ? '0 : bit_pos_q + PW'(1);
			end else begin
				sample_cnt_d = sample_cnt_q + 8'd1;
			end
		end

		// The store is addressed with the byte that the next tick will need.
		q_off_d = bit_pos_d - POS_SYNC_END;
		idx_d   = AW'(q_off_d >> 3);
		if (bit_pos_d < POS_SYNC_END || idx_d >= IDX_CRC) begin
			rd_addr = '0;
		end else begin
			rd_addr = idx_d;
		end
	end

	assign amp_ext = {1'b0, cfg.amplitude};

	nct_ram #(
		.WIDTH  (8),
		.DEPTH  (STORE_BYTES),
		.ADDR_W (AW)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (byte_value_s1),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			bit_pos_q    <= '0;
			sample_cnt_q <= 8'd0;
			crc_q        <= 8'h00;
			out_valid_q  <= 1'b0;
			byte_vld_q   <= '0;
			rd_vld_q     <= 1'b0;
			fwd_hit_q    <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			bit_pos_q    <= bit_pos_d;
			sample_cnt_q <= sample_cnt_d;
			crc_q        <= crc_d;
			if (tick_go) begin
				out_valid_q <= 1'b1;
			end else if (smp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				byte_vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q  <= byte_vld_q[rd_addr];
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready) begin
			req_type_s1   <= req.req_type;
			byte_index_s1 <= req.byte_index;
			byte_value_s1 <= req.byte_value;
		end
		fwd_data_q <= byte_value_s1;
		if (tick_go) begin
			sample_value_q <= cur_bit ? sample_value_t'(amp_ext)
			                          : sample_value_t'(16'd0 - amp_ext);
			sent_bit_q     <= cur_bit;
			packet_start_q <= first;
			packet_end_q   <= last && (bit_pos_q == POS_LAST);
		end
	end

	assign smp.valid        = out_valid_q;
	assign smp.sample_value = sample_value_q;
	assign smp.sent_bit     = sent_bit_q;
	assign smp.packet_start = packet_start_q;
	assign smp.packet_end   = packet_end_q;

endmodule

// ===== dv/nrz_crc8_frame_transmitter_tb.sv =====
`timescale 1ns / 1ps
module nrz_crc8_frame_transmitter_tb;
	import nct_pkg::*;

	localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
	localparam int STORE_BYTES   = PAYLOAD_BYTES - 1;
	localparam int FRAME_BITS    = SYNC_BITS + 8 * PAYLOAD_BYTES;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		sample_value_t sample_value;
		logic          sent_bit;
		logic          packet_start;
		logic          packet_end;
	} frame_smp_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_PERIODIC,
		RX_RANDOM
	} rx_pattern_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	nct_req_if req_bus ();
	nct_smp_if smp_bus ();

	nrz_crc8_frame_transmitter #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.smp     (smp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Transmitter state as the block should hold it.
	byte_value_t model_payload [STORE_BYTES] = '{default: 8'h00};
	cfg_t        model_cfg = '{AMPLITUDE_RST, SPS_RST, FRAME_MARKER_RST};
	int unsigned tx_bit_pos = 0;
	logic [7:0]  tx_sample_cnt = 8'h00;
	logic [7:0]  tx_crc = 8'h00;

	frame_smp_t  expected_samples [$];
	int          errors = 0;
	int          stuck_cycles = 0;
	int          burst_left = 0;

	rx_pattern_t rx_pattern = RX_ALWAYS;
	int unsigned rx_cycle = 0;
	int unsigned rx_pattern_left = 0;
	int unsigned rx_period = 2;
	int unsigned rx_hold = 1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic frame_smp_t frame_predict_tick();
		frame_smp_t  s;
		logic        bit_v;
		logic        in_payload;
		logic        in_crc;
		logic        last_sample;
		int unsigned offset;
		int unsigned sps;
		in_payload = 1'b0;
		in_crc = 1'b0;
		if (tx_bit_pos >= FRAME_BITS)
			tx_bit_pos = 0;
		s.packet_start = (tx_bit_pos == 0 && tx_sample_cnt == 8'h00);
		if (s.packet_start)
			tx_crc = 8'h00;
		if (tx_bit_pos < SYNC_BITS) begin
			bit_v = model_cfg.frame_marker[31 - tx_bit_pos];
		end else begin
			offset = tx_bit_pos - SYNC_BITS;
			if (offset / 8 < STORE_BYTES) begin
				bit_v = model_payload[offset / 8][7 - offset % 8];
				in_payload = 1'b1;
			end else begin
				bit_v = tx_crc[7];
				in_crc = 1'b1;
			end
		end
		sps = (model_cfg.samples_per_symbol == 8'd0) ? 1 : model_cfg.samples_per_symbol;
		last_sample = (tx_sample_cnt + 1 >= sps);
		s.sample_value = bit_v ? sample_value_t'({1'b0, model_cfg.amplitude})
			: -sample_value_t'({1'b0, model_cfg.amplitude});
		s.sent_bit = bit_v;
		s.packet_end = last_sample && (tx_bit_pos == FRAME_BITS - 1);
		if (last_sample) begin
			if (in_payload)
				tx_crc = {tx_crc[6:0], 1'b0} ^ ((tx_crc[7] ^ bit_v) ? CRC_POLY : 8'h00);
			else if (in_crc)
				tx_crc = {tx_crc[6:0], 1'b0};
			tx_sample_cnt = 8'h00;
			tx_bit_pos = (tx_bit_pos + 1 >= FRAME_BITS) ? 0 : tx_bit_pos + 1;
		end else begin
			tx_sample_cnt = tx_sample_cnt + 8'd1;
		end
		return s;
	endfunction

	// Results are checked before the same edge's request is predicted; a sample
	// always trails its tick through the input stage and the output register.
	always @(posedge clk) begin
		frame_smp_t want;
		logic       active;
		active = 1'b0;
		if (arst_n) begin
			if (smp_bus.valid && smp_bus.ready) begin
				active = 1'b1;
				if (expected_samples.size() == 0) begin
					$error("sample transfer with none expected: sample_value %0d",
						$signed(smp_bus.sample_value));
					errors++;
				end else begin
					want = expected_samples.pop_front();
					if (smp_bus.sample_value !== want.sample_value) begin
						$error("sample_value expected %0d actual %0d",
							$signed(want.sample_value), $signed(smp_bus.sample_value));
						errors++;
					end
					if (smp_bus.sent_bit !== want.sent_bit) begin
						$error("sent_bit expected %0b actual %0b",
							want.sent_bit, smp_bus.sent_bit);
						errors++;
					end
					if (smp_bus.packet_start !== want.packet_start) begin
						$error("packet_start expected %0b actual %0b",
							want.packet_start, smp_bus.packet_start);
						errors++;
					end
					if (smp_bus.packet_end !== want.packet_end) begin
						$error("packet_end expected %0b actual %0b",
							want.packet_end, smp_bus.packet_end);
						errors++;
					end
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				active = 1'b1;
				if (req_bus.req_type == REQ_LOAD) begin
					if (req_bus.byte_index < STORE_BYTES)
						model_payload[req_bus.byte_index] = req_bus.byte_value;
				end else begin
					expected_samples.push_back(frame_predict_tick());
				end
			end
			if (psel && penable)
				active = 1'b1;
			stuck_cycles = active ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (rx_pattern_left == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(2));
			rx_period = $urandom_range(2, 16);
			rx_hold = $urandom_range(1, rx_period - 1);
			rx_pattern_left = $urandom_range(32, 400);
		end else begin
			rx_pattern_left--;
		end
		rx_cycle++;
		case (rx_pattern)
			RX_ALWAYS: smp_bus.ready <= 1'b1;
			RX_PERIODIC: smp_bus.ready <= (rx_cycle % rx_period) >= rx_hold;
			default: smp_bus.ready <= ($urandom_range(3) != 0);
		endcase
	end

	task automatic send_item(req_type_t kind, byte_index_t idx, byte_value_t value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		req_bus.valid <= 1'b1;
		req_bus.req_type <= kind;
		req_bus.byte_index <= idx;
		req_bus.byte_value <= value;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic send_ticks(int count);
		repeat (count)
			send_item(REQ_TICK, byte_index_t'($urandom), byte_value_t'($urandom));
	endtask

	task automatic send_random_item(int tick_pct);
		if ($urandom_range(99) < tick_pct)
			send_item(REQ_TICK, byte_index_t'($urandom), byte_value_t'($urandom));
		else
			send_item(REQ_LOAD, byte_index_t'($urandom_range(63)),
				byte_value_t'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		burst_left = 0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [APB_DW-1:0] value);
		logic [APB_AW-1:0] addr;
		addr = APB_AW'(4 * idx);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_AMPLITUDE: model_cfg.amplitude = value[14:0];
			REG_SPS: model_cfg.samples_per_symbol = value[7:0];
			default: model_cfg.frame_marker = value;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_item(REQ_LOAD, 6'd0, 8'hFF);
		send_item(REQ_LOAD, 6'd62, 8'h81);
		send_item(REQ_LOAD, 6'd63, 8'hAA);
		send_ticks(8);
	endtask

	task automatic test_register_extremes();
		write_register(REG_AMPLITUDE, 32'd32767);
		write_register(REG_SPS, 32'd1);
		write_register(REG_FRAME_MARKER, 32'hFFFF_FFFF);
		send_ticks(5);
		write_register(REG_AMPLITUDE, 32'd0);
		write_register(REG_FRAME_MARKER, 32'h0000_0000);
		send_ticks(5);
	endtask

	// Runs past a whole packet at one sample per bit while payload bytes keep
	// changing under the transmitter.
	task automatic test_full_packet();
		write_register(REG_AMPLITUDE, $urandom_range(1, 32767));
		write_register(REG_SPS, 32'd1);
		write_register(REG_FRAME_MARKER, $urandom);
		for (int i = 0; i < 570; i++) begin
			if (i % 38 == 0)
				send_item(REQ_LOAD, byte_index_t'($urandom_range(STORE_BYTES - 1)),
					byte_value_t'($urandom));
			else
				send_ticks(1);
		end
	endtask

	task automatic test_symbol_length();
		write_register(REG_SPS, 32'd12);
		send_ticks(7);
		write_register(REG_SPS, 32'd3);
		send_ticks(6);
		write_register(REG_SPS, 32'd255);
		send_ticks(10);
		write_register(REG_SPS, 32'd0);
		send_ticks(8);
	endtask

	task automatic test_random_traffic();
		for (int n = 0; n < 30; n++) begin
			if (n % 15 == 0) begin
				write_register(REG_AMPLITUDE, $urandom_range(32767));
				write_register(REG_SPS, ($urandom_range(4) == 0) ? $urandom_range(255)
					: $urandom_range(3));
				write_register(REG_FRAME_MARKER, $urandom);
			end else if ($urandom_range(20) == 0) begin
				wait_drained();
			end
			send_random_item(80);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.req_type <= REQ_LOAD;
		req_bus.byte_index <= '0;
		req_bus.byte_value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_full_packet();
		test_symbol_length();
		test_random_traffic();
		wait_drained();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/nct_pkg.sv
src/nct_if.sv
src/nct_ram.sv
src/nct_cfg_regs.sv
src/nrz_crc8_frame_transmitter.sv
dv/nrz_crc8_frame_transmitter_tb.sv
